/* hw/rtl/perd_pkg.sv */
`timescale 1ns / 1ps
// perd_pkg: shared codes and fixed field widths for the pending event dispatcher
// no dependencies; used by the channel interfaces and the top level

package perd_pkg;

	localparam int FUNC_W    = 2;
	localparam int SIG_W     = 5;
	localparam int CNT_OUT_W = 16;
	localparam int TOT_OUT_W = 21;
	localparam int MASK_W    = 32;

	// operation codes carried in the func field
	typedef enum logic [FUNC_W-1:0] {
		FUNC_ARRIVE   = 2'd0,
		FUNC_DISPATCH = 2'd1,
		FUNC_RETURN   = 2'd2,
		FUNC_NONE     = 2'd3
	} func_t;

endpackage

/* hw/rtl/perd_if.sv */
`timescale 1ns / 1ps
// perd_req_if, perd_rsp_if, perd_cfg_if: valid/ready channels of the dispatcher
// depends on perd_pkg for field widths

interface perd_req_if;
	logic                        valid;
	logic                        ready;
	logic [perd_pkg::FUNC_W-1:0] func;
	logic [perd_pkg::SIG_W-1:0]  signal_number;
	logic                        in_managed_code;
	logic                        io_waiting;

	modport source (output valid, func, signal_number, in_managed_code, io_waiting,
		input ready);
	modport sink (input valid, func, signal_number, in_managed_code, io_waiting,
		output ready);
endinterface

interface perd_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           io_abort;
	logic                           trap_request;
	logic                           dispatched;
	logic [perd_pkg::SIG_W-1:0]     signal_code;
	logic [perd_pkg::CNT_OUT_W-1:0] signal_count;
	logic [perd_pkg::TOT_OUT_W-1:0] pending_total;

	modport source (output valid, io_abort, trap_request, dispatched, signal_code,
		signal_count, pending_total, input ready);
	modport sink (input valid, io_abort, trap_request, dispatched, signal_code,
		signal_count, pending_total, output ready);
endinterface

interface perd_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [perd_pkg::MASK_W-1:0] enable_mask;

	modport source (output valid, enable_mask, input ready);
	modport sink (input valid, enable_mask, output ready);
endinterface

/* hw/rtl/pending_event_round_robin_dispatch_top.sv */
`timescale 1ns / 1ps
// pending_event_round_robin_dispatch_top: per-signal pending counters, running total,
// round-robin dispatch; one item at a time through a small sequencer
// next item accepted once the sequencer is back in idle; the scan checks one counter per cycle
// reset: async active low clears all control state and the counter valid bits at once
// depends on perd_pkg, perd_if, perd_cnt_mem

module pending_event_round_robin_dispatch_top #(
	parameter int NUM_SIGNALS = 32,
	parameter int COUNT_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	perd_req_if.sink   req,
	perd_rsp_if.source rsp,
	perd_cfg_if.sink   cfg
);

	localparam int IDX_W = $clog2(NUM_SIGNALS);
	// total never exceeds NUM_SIGNALS * (2^COUNT_WIDTH - 1)
	localparam int TOT_W = COUNT_WIDTH + IDX_W;
	localparam logic [IDX_W-1:0]       LAST_IDX = IDX_W'(NUM_SIGNALS - 1);
	localparam logic [31:0]            NSIG     = 32'(NUM_SIGNALS);
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = {COUNT_WIDTH{1'b1}};

	typedef enum logic [2:0] {
		S_IDLE,
		S_ARR,
		S_SCAN,
		S_DONE
	} state_t;

	state_t state_q;

	// architectural state
	logic [perd_pkg::MASK_W-1:0] enable_mask_q;
	logic [IDX_W-1:0]            last_served_q;
	logic [TOT_W-1:0]            total_q;
	logic                        trap_pending_q;
	logic                        handler_active_q;

	// sequencer working registers
	logic [IDX_W-1:0] scan_idx_q;   // address whose read data arrives this cycle
	logic [IDX_W-1:0] step_q;       // entries already looked at in this scan
	logic             managed_q;
	logic             iowait_q;

	// result held until the output register is free
	logic                       res_abort_q;
	logic                       res_trap_q;
	logic                       res_disp_q;
	logic [IDX_W-1:0]           res_code_q;
	logic [COUNT_WIDTH-1:0]     res_count_q;

	// output register
	logic                           out_valid_q;
	logic                           out_abort_q;
	logic                           out_trap_q;
	logic                           out_disp_q;
	logic [perd_pkg::SIG_W-1:0]     out_code_q;
	logic [perd_pkg::CNT_OUT_W-1:0] out_count_q;
	logic [perd_pkg::TOT_OUT_W-1:0] out_total_q;

	// counter store access
	logic [IDX_W-1:0]       rd_addr;
	logic [COUNT_WIDTH-1:0] rd_val;
	logic                   wr_en;
	logic [COUNT_WIDTH-1:0] wr_data;
	logic                   inv_en;

	logic                   accept;
	logic [31:0]            sig_ext;
	logic                   sig_ok;
	logic [IDX_W-1:0]       sig_idx;
	logic [IDX_W-1:0]       next_last;
	logic [IDX_W-1:0]       next_scan;
	logic                   cnt_nz;
	logic                   cnt_sat;
	logic [TOT_W-1:0]       cnt_ext;
	logic                   out_free;

	// padded views for truncating to the fixed result widths
	logic [IDX_W+perd_pkg::SIG_W-1:0]           code_pad;
	logic [COUNT_WIDTH+perd_pkg::CNT_OUT_W-1:0] count_pad;
	logic [TOT_W+perd_pkg::TOT_OUT_W-1:0]       total_pad;

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
		logic [IDX_W-1:0] r;
		r = (i == LAST_IDX) ? '0 : i + IDX_W'(1);
		return r;
	endfunction

	perd_cnt_mem #(
		.DEPTH (NUM_SIGNALS),
		.WIDTH (COUNT_WIDTH)
	) u_cnt_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (rd_addr),
		.rd_data  (rd_val),
		.wr_en    (wr_en),
		.wr_addr  (scan_idx_q),
		.wr_data  (wr_data),
		.inv_en   (inv_en),
		.inv_addr (scan_idx_q)
	);

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	// arrivals beyond the counter array or with their enable bit clear are dropped
	assign sig_ext = {{(32 - perd_pkg::SIG_W){1'b0}}, req.signal_number};
	assign sig_ok  = (sig_ext < NSIG) && enable_mask_q[req.signal_number];
	assign sig_idx = sig_ext[IDX_W-1:0];

	assign next_last = wrap_inc(last_served_q);
	assign next_scan = wrap_inc(scan_idx_q);

	// read address: first entry on accept, then one entry further per scan cycle
	always_comb begin
		case (state_q)
			S_IDLE:  rd_addr = (req.func == perd_pkg::FUNC_DISPATCH) ? next_last : sig_idx;
			S_SCAN:  rd_addr = next_scan;
			default: rd_addr = scan_idx_q;
		endcase
	end

	// shared compare and increment on the counter just read
	assign cnt_nz  = (rd_val != '0);
	assign cnt_sat = (rd_val == CNT_MAX);
	assign cnt_ext = {{(TOT_W - COUNT_WIDTH){1'b0}}, rd_val};
	assign wr_data = rd_val + COUNT_WIDTH'(1);
	assign wr_en   = (state_q == S_ARR) && !cnt_sat;
	assign inv_en  = (state_q == S_SCAN) && cnt_nz;

	assign out_free = !out_valid_q || rsp.ready;

	assign code_pad  = {{perd_pkg::SIG_W{1'b0}}, res_code_q};
	assign count_pad = {{perd_pkg::CNT_OUT_W{1'b0}}, res_count_q};
	assign total_pad = {{perd_pkg::TOT_OUT_W{1'b0}}, total_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			enable_mask_q    <= '0;
			last_served_q    <= IDX_W'(1);
			total_q          <= '0;
			trap_pending_q   <= 1'b0;
			handler_active_q <= 1'b0;
			scan_idx_q       <= '0;
			step_q           <= '0;
			managed_q        <= 1'b0;
			iowait_q         <= 1'b0;
			res_abort_q      <= 1'b0;
			res_trap_q       <= 1'b0;
			res_disp_q       <= 1'b0;
			res_code_q       <= '0;
			res_count_q      <= '0;
			out_valid_q      <= 1'b0;
			out_abort_q      <= 1'b0;
			out_trap_q       <= 1'b0;
			out_disp_q       <= 1'b0;
			out_code_q       <= '0;
			out_count_q      <= '0;
			out_total_q      <= '0;
		end else begin
			if (cfg.valid) begin
				enable_mask_q <= cfg.enable_mask;
			end
			// in S_DONE the output register is reloaded instead
			if (out_valid_q && rsp.ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						scan_idx_q  <= rd_addr;
						step_q      <= '0;
						managed_q   <= req.in_managed_code;
						iowait_q    <= req.io_waiting;
						res_abort_q <= 1'b0;
						res_trap_q  <= 1'b0;
						res_disp_q  <= 1'b0;
						res_code_q  <= '0;
						res_count_q <= '0;
						case (req.func)
							perd_pkg::FUNC_ARRIVE: begin
								state_q <= sig_ok ? S_ARR : S_DONE;
							end
							perd_pkg::FUNC_DISPATCH: begin
								state_q <= S_SCAN;
							end
							perd_pkg::FUNC_RETURN: begin
								handler_active_q <= 1'b0;
								state_q          <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end

				S_ARR: begin
					// saturated counter leaves the total alone, flags still apply
					if (!cnt_sat) begin
						total_q <= total_q + TOT_W'(1);
					end
					if (iowait_q) begin
						res_abort_q <= 1'b1;
					end else if (managed_q && !trap_pending_q && !handler_active_q) begin
						res_trap_q     <= 1'b1;
						trap_pending_q <= 1'b1;
					end
					state_q <= S_DONE;
				end

				S_SCAN: begin
					if (cnt_nz) begin
						res_disp_q       <= 1'b1;
						res_code_q       <= scan_idx_q;
						res_count_q      <= rd_val;
						last_served_q    <= scan_idx_q;
						total_q          <= (total_q >= cnt_ext) ? total_q - cnt_ext : '0;
						trap_pending_q   <= 1'b0;
						handler_active_q <= 1'b1;
						state_q          <= S_DONE;
					end else if (step_q == LAST_IDX) begin
						// full circle with nothing pending
						state_q <= S_DONE;
					end else begin
						scan_idx_q <= next_scan;
						step_q     <= step_q + IDX_W'(1);
					end
				end

				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_abort_q <= res_abort_q;
						out_trap_q  <= res_trap_q;
						out_disp_q  <= res_disp_q;
						out_code_q  <= code_pad[perd_pkg::SIG_W-1:0];
						out_count_q <= count_pad[perd_pkg::CNT_OUT_W-1:0];
						out_total_q <= total_pad[perd_pkg::TOT_OUT_W-1:0];
						state_q     <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.io_abort      = out_abort_q;
	assign rsp.trap_request  = out_trap_q;
	assign rsp.dispatched    = out_disp_q;
	assign rsp.signal_code   = out_code_q;
	assign rsp.signal_count  = out_count_q;
	assign rsp.pending_total = out_total_q;

endmodule

/* hw/rtl/perd_cnt_mem.sv */
`timescale 1ns / 1ps
// perd_cnt_mem: pending counter store, one write port and one registered read port
// per-entry valid flops make unwritten or invalidated entries read as zero; no package use

module perd_cnt_mem #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     inv_en,
	input  logic [$clog2(DEPTH)-1:0] inv_addr
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] rd_raw_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_raw_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (inv_en) begin
				valid_q[inv_addr] <= 1'b0;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	// entry not valid reads as zero
	assign rd_data = rd_valid_q ? rd_raw_q : '0;

endmodule

/* tb/perd_dispatch_monitor.sv */
`timescale 1ns / 1ps
// perd_dispatch_monitor: watches the request, result and enable-mask channels of the
// pending event dispatcher, predicts each result and compares it; uses perd_pkg, perd_if

module perd_dispatch_monitor (
	input  logic clk,
	input  logic arst_n,
	perd_req_if  req,
	perd_rsp_if  rsp,
	perd_cfg_if  cfg,
	output int   mismatches,
	output int   awaiting
);

	localparam int SIG_W     = perd_pkg::SIG_W;
	localparam int CNT_OUT_W = perd_pkg::CNT_OUT_W;
	localparam int TOT_OUT_W = perd_pkg::TOT_OUT_W;
	localparam int MASK_W    = perd_pkg::MASK_W;
	localparam int NSIG = 32;
	localparam logic [CNT_OUT_W-1:0] COUNT_CEIL = '1;

	typedef struct packed {
		logic                 io_abort;
		logic                 trap_request;
		logic                 dispatched;
		logic [SIG_W-1:0]     signal_code;
		logic [CNT_OUT_W-1:0] signal_count;
		logic [TOT_OUT_W-1:0] pending_total;
	} dispatch_result_t;

	// shadow of the dispatcher state
	logic [CNT_OUT_W-1:0] pend_count [NSIG];
	logic [SIG_W-1:0]     last_served_sig;
	logic [TOT_OUT_W-1:0] total_pend;
	logic                 trap_armed;
	logic                 handler_busy;
	logic [MASK_W-1:0]    enable_bits;

	dispatch_result_t expected_q [$];

	task automatic predict_step(input perd_pkg::func_t op, input logic [SIG_W-1:0] sig,
		input logic managed, input logic iowait, output dispatch_result_t res);
		logic [SIG_W-1:0] idx;
		bit found;
		res = '0;
		found = 0;
		case (op)
		perd_pkg::FUNC_ARRIVE: begin
			if (enable_bits[sig]) begin
				if (pend_count[sig] != COUNT_CEIL) begin
					pend_count[sig] = pend_count[sig] + 1'b1;
					total_pend = total_pend + 1'b1;
				end
				if (iowait) begin
					res.io_abort = 1'b1;
				end else if (managed && !trap_armed && !handler_busy) begin
					trap_armed = 1'b1;
					res.trap_request = 1'b1;
				end
			end
		end
		perd_pkg::FUNC_DISPATCH: begin
			idx = last_served_sig;
			for (int n = 0; n < NSIG && !found; n++) begin
				idx = idx + 1'b1;
				if (pend_count[idx] != '0) begin
					found = 1;
					res.dispatched = 1'b1;
					res.signal_code = idx;
					res.signal_count = pend_count[idx];
					last_served_sig = idx;
					total_pend = (total_pend >= pend_count[idx]) ?
						total_pend - pend_count[idx] : '0;
					pend_count[idx] = '0;
					trap_armed = 1'b0;
					handler_busy = 1'b1;
				end
			end
		end
		perd_pkg::FUNC_RETURN: begin
			handler_busy = 1'b0;
		end
		default: begin
		end
		endcase
		res.pending_total = total_pend;
	endtask

	task automatic check_field(input string field, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		dispatch_result_t predicted;
		dispatch_result_t oldest;
		if (!arst_n) begin
			foreach (pend_count[i])
				pend_count[i] = '0;
			last_served_sig = SIG_W'(1);
			total_pend = '0;
			trap_armed = 1'b0;
			handler_busy = 1'b0;
			enable_bits = '0;
			expected_q.delete();
			mismatches = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				enable_bits = cfg.enable_mask;
			if (req.valid && req.ready) begin
				predict_step(perd_pkg::func_t'(req.func), req.signal_number,
					req.in_managed_code, req.io_waiting, predicted);
				expected_q.push_back(predicted);
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t result with nothing outstanding: total %0d", $realtime,
							rsp.pending_total);
				end else begin
					oldest = expected_q.pop_front();
					check_field("io_abort", oldest.io_abort, rsp.io_abort);
					check_field("trap_request", oldest.trap_request, rsp.trap_request);
					check_field("dispatched", oldest.dispatched, rsp.dispatched);
					check_field("signal_code", oldest.signal_code, rsp.signal_code);
					check_field("signal_count", oldest.signal_count, rsp.signal_count);
					check_field("pending_total", oldest.pending_total, rsp.pending_total);
				end
			end
		end
		awaiting = expected_q.size();
	end

endmodule

/* tb/tb_pending_event_round_robin_dispatch_top.sv */
`timescale 1ns / 1ps
// tb_pending_event_round_robin_dispatch_top: drives the dispatcher with directed and random
// items under several idle patterns; uses perd_pkg, perd_if, perd_dispatch_monitor and the dut

module tb_pending_event_round_robin_dispatch_top;

	localparam int SIG_W  = perd_pkg::SIG_W;
	localparam int MASK_W = perd_pkg::MASK_W;
	localparam int NUM_SIGNALS = 32;
	localparam int SETTLE_CYCLES = NUM_SIGNALS + 4;
	localparam int PHASE_ITEMS = 225;

	logic clk = 1'b0;
	logic arst_n;

	perd_req_if req_ch ();
	perd_rsp_if rsp_ch ();
	perd_cfg_if cfg_ch ();

	int mismatches;
	int awaiting;

	// percentages for the sender gap and the receiver stall of the current phase
	int idle_pct;
	int stall_pct;

	// mask the block holds right now, and the signal last sent
	logic [MASK_W-1:0] active_mask;
	logic [SIG_W-1:0]  last_sig;

	pending_event_round_robin_dispatch_top #(
		.NUM_SIGNALS(NUM_SIGNALS),
		.COUNT_WIDTH(16)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	perd_dispatch_monitor monitor (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg       (cfg_ch),
		.mismatches(mismatches),
		.awaiting  (awaiting)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// result side: ready changes on the falling edge, stalls at the phase rate
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// hard stop in case the block hangs
	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

	// one item through the request channel; called and returns at a falling edge,
	// valid stays high afterwards so back-to-back items need no drop
	task automatic send_item(input perd_pkg::func_t op, input logic [SIG_W-1:0] sig,
		input logic managed, input logic iowait);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid           <= 1'b1;
		req_ch.func            <= op;
		req_ch.signal_number   <= sig;
		req_ch.in_managed_code <= managed;
		req_ch.io_waiting      <= iowait;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	// mask writes only happen with the block drained and settled
	task automatic load_enable_mask(input logic [MASK_W-1:0] mask);
		req_ch.valid <= 1'b0;
		while (awaiting != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_ch.valid       <= 1'b1;
		cfg_ch.enable_mask <= mask;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		active_mask = mask;
	endtask

	// mostly enabled signals, often the same one again so counts build up
	function automatic logic [SIG_W-1:0] pick_signal();
		logic [SIG_W-1:0] s;
		if ($urandom_range(99) < 30)
			return last_sig;
		s = SIG_W'($urandom_range(NUM_SIGNALS - 1));
		if (active_mask != '0 && $urandom_range(99) < 80) begin
			while (!active_mask[s])
				s = SIG_W'($urandom_range(NUM_SIGNALS - 1));
		end
		return s;
	endfunction

	// random traffic: arrivals dominate, mixed at random with dispatches, returns and unused codes;
	// arrivals of masked-off signals are sent but not counted
	task automatic random_traffic(input int n_items);
		int sent;
		int pick;
		logic [SIG_W-1:0] sig;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				sig = pick_signal();
				last_sig = sig;
				send_item(perd_pkg::FUNC_ARRIVE, sig, 1'($urandom_range(1)),
					($urandom_range(3) == 0));
				if (active_mask[sig])
					sent++;
			end else begin
				if (pick < 80)
					send_item(perd_pkg::FUNC_DISPATCH, SIG_W'($urandom), 1'($urandom),
						1'($urandom));
				else if (pick < 95)
					send_item(perd_pkg::FUNC_RETURN, SIG_W'($urandom), 1'($urandom),
						1'($urandom));
				else
					send_item(perd_pkg::FUNC_NONE, SIG_W'($urandom), 1'($urandom),
						1'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		int idle_plan [4];
		int stall_plan [4];
		logic [MASK_W-1:0] mask_plan [4];

		idle_plan  = '{0, 82, 0, 24};
		stall_plan = '{0, 0, 82, 24};
		mask_plan  = '{32'hFFFF_FFFF, $urandom, 32'h8000_0001, $urandom};

		// every input known from time zero
		arst_n                 = 1'b0;
		idle_pct               = 0;
		stall_pct              = 0;
		active_mask            = '0;
		last_sig               = '0;
		req_ch.valid           = 1'b0;
		req_ch.func            = perd_pkg::FUNC_ARRIVE;
		req_ch.signal_number   = '0;
		req_ch.in_managed_code = 1'b0;
		req_ch.io_waiting      = 1'b0;
		rsp_ch.ready           = 1'b0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.enable_mask     = '0;

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset mask is all zero: nothing counts, nothing to dispatch
		send_item(perd_pkg::FUNC_DISPATCH, 5'd0, 1'b0, 1'b0);
		send_item(perd_pkg::FUNC_ARRIVE, 5'd3, 1'b1, 1'b0);
		send_item(perd_pkg::FUNC_NONE, 5'd31, 1'b1, 1'b1);
		send_item(perd_pkg::FUNC_RETURN, 5'd0, 1'b0, 1'b0);

		load_enable_mask(32'hFFFF_FFFF);
		// first managed arrival raises the trap, the next one must not
		send_item(perd_pkg::FUNC_ARRIVE, 5'd0, 1'b1, 1'b0);
		send_item(perd_pkg::FUNC_ARRIVE, 5'd31, 1'b1, 1'b0);
		// arrival during an i/o wait aborts the wait
		send_item(perd_pkg::FUNC_ARRIVE, 5'd31, 1'b1, 1'b1);
		send_item(perd_pkg::FUNC_ARRIVE, 5'd5, 1'b0, 1'b0);
		// scan starts after entry 1, so signal 5 goes first
		send_item(perd_pkg::FUNC_DISPATCH, 5'd0, 1'b0, 1'b0);
		// handler active blocks a new trap until it returns
		send_item(perd_pkg::FUNC_ARRIVE, 5'd2, 1'b1, 1'b0);
		send_item(perd_pkg::FUNC_RETURN, 5'd0, 1'b0, 1'b0);
		send_item(perd_pkg::FUNC_ARRIVE, 5'd2, 1'b1, 1'b0);
		// 31, then wrap around to 0, then 2, then nothing left
		send_item(perd_pkg::FUNC_DISPATCH, 5'd0, 1'b0, 1'b0);
		send_item(perd_pkg::FUNC_DISPATCH, 5'd0, 1'b0, 1'b0);
		send_item(perd_pkg::FUNC_DISPATCH, 5'd0, 1'b0, 1'b0);
		send_item(perd_pkg::FUNC_DISPATCH, 5'd0, 1'b0, 1'b0);
		send_item(perd_pkg::FUNC_NONE, 5'd0, 1'b0, 1'b0);
		send_item(perd_pkg::FUNC_RETURN, 5'd0, 1'b0, 1'b0);

		// repeated arrivals on counter 7 and one on counter 8, with the trap and abort flags
		send_item(perd_pkg::FUNC_ARRIVE, 5'd7, 1'b1, 1'b0);
		send_item(perd_pkg::FUNC_ARRIVE, 5'd7, 1'b0, 1'b1);
		send_item(perd_pkg::FUNC_ARRIVE, 5'd8, 1'b1, 1'b0);
		send_item(perd_pkg::FUNC_DISPATCH, 5'd0, 1'b0, 1'b0);
		send_item(perd_pkg::FUNC_DISPATCH, 5'd0, 1'b0, 1'b0);
		send_item(perd_pkg::FUNC_RETURN, 5'd0, 1'b0, 1'b0);

		// random phases, each with its own mask and idle pattern
		for (int p = 0; p < 4; p++) begin
			load_enable_mask(mask_plan[p]);
			idle_pct  = idle_plan[p];
			stall_pct = stall_plan[p];
			random_traffic(PHASE_ITEMS);
		end

		// drain: every result in, then let the sequencer settle
		req_ch.valid <= 1'b0;
		while (awaiting != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
